// File: design/rpi_pkg.sv
// Shared constants, register codes, types and helpers of the ray/plane intersection block.
package rpi_pkg;

   localparam int FRAC_BITS = 16;
   localparam int WORD_BITS = 32;

   // Field widths
   localparam int COORD_W = 32;
   localparam int VEC_W   = 18;
   localparam int THR_W   = 17;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = 3;

   // Derived arithmetic widths
   localparam int DN_W    = 2 * VEC_W;              // dir * normal
   localparam int COSF_W  = DN_W + 2;               // sum of three
   localparam int COS_W   = COSF_W - FRAC_BITS;     // cos after shift
   localparam int DIFF_W  = COORD_W + 1;            // origin - center
   localparam int ND_W    = VEC_W + DIFF_W;         // normal * diff
   localparam int DISTF_W = ND_W + 2;               // sum of three
   localparam int DIST_W  = DISTF_W - FRAC_BITS;    // dist after shift
   localparam int NUM_W   = DIST_W + FRAC_BITS;     // |dist| << FRAC_BITS
   localparam int DEN_W   = COS_W;                  // |cos|
   localparam int GL_W    = 27;                     // low part of gamma
   localparam int GH_W    = NUM_W - GL_W;           // high part of gamma
   localparam int PL_W    = GL_W + 1 + VEC_W;
   localparam int PH_W    = GH_W + 1 + VEC_W;
   localparam int T_W     = PH_W + GL_W;            // gamma * dir
   localparam int TS_W    = T_W - FRAC_BITS;        // after floor shift
   localparam int SUM_W   = TS_W + 1;

   // Register indexes
   localparam logic [IDX_W-1:0] REG_CENTER_X = 3'd0;
   localparam logic [IDX_W-1:0] REG_CENTER_Y = 3'd1;
   localparam logic [IDX_W-1:0] REG_CENTER_Z = 3'd2;
   localparam logic [IDX_W-1:0] REG_NORMAL_X = 3'd3;
   localparam logic [IDX_W-1:0] REG_NORMAL_Y = 3'd4;
   localparam logic [IDX_W-1:0] REG_NORMAL_Z = 3'd5;
   localparam logic [IDX_W-1:0] REG_TAN_EPS  = 3'd6;
   localparam logic [IDX_W-1:0] REG_MIN_GAM  = 3'd7;

   // Reset values
   localparam logic [VEC_W-1:0] NORMAL_Z_RESET = 18'd65536;
   localparam logic [THR_W-1:0] TAN_EPS_RESET  = 17'd7;
   localparam logic [THR_W-1:0] MIN_GAM_RESET  = 17'd1;

   // Side data carried along the divider
   typedef struct packed {
      logic signed [COORD_W-1:0] org_x;
      logic signed [COORD_W-1:0] org_y;
      logic signed [COORD_W-1:0] org_z;
      logic signed [VEC_W-1:0]   dir_x;
      logic signed [VEC_W-1:0]   dir_y;
      logic signed [VEC_W-1:0]   dir_z;
      logic                      parallel;
      logic                      neg;
      logic [WORD_BITS-1:0]      dist_miss;
      logic [WORD_BITS-1:0]      dist_hit;
   } pay_type;

   // Clamp a wide signed sum to a signed word
   function automatic logic [WORD_BITS-1:0] sat_word(input logic signed [SUM_W-1:0] v);
      logic [WORD_BITS-1:0] r;
      if (v > $signed(SUM_W'({1'b0, {(WORD_BITS-1){1'b1}}}))) begin
         r = {1'b0, {(WORD_BITS-1){1'b1}}};
      end else if (v < $signed({{(SUM_W-WORD_BITS+1){1'b1}}, {(WORD_BITS-1){1'b0}}})) begin
         r = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         r = v[WORD_BITS-1:0];
      end
      return r;
   endfunction

endpackage

// File: design/rpi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side data.
module rpi_div #(
   parameter int NUM_W = rpi_pkg::NUM_W,
   parameter int DEN_W = rpi_pkg::DEN_W,
   parameter int PAY_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] in_den,
   input  logic [PAY_W-1:0] in_pay,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo,
   output logic [PAY_W-1:0] out_pay
);

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_stage
         logic             v_ff;
         logic [NUM_W-1:0] nq_ff;
         logic [DEN_W-1:0] rem_ff;
         logic [DEN_W-1:0] den_ff;
         logic [PAY_W-1:0] pay_ff;
         logic             v_src;
         logic [NUM_W-1:0] nq_src;
         logic [DEN_W-1:0] rem_src;
         logic [DEN_W-1:0] den_src;
         logic [PAY_W-1:0] pay_src;
         logic [DEN_W:0]   trial;
         logic             qbit;
         logic [DEN_W:0]   diff;

         if (k == 0) begin : g_first
            assign v_src   = in_valid;
            assign nq_src  = in_num;
            assign rem_src = '0;
            assign den_src = in_den;
            assign pay_src = in_pay;
         end else begin : g_next
            assign v_src   = g_stage[k-1].v_ff;
            assign nq_src  = g_stage[k-1].nq_ff;
            assign rem_src = g_stage[k-1].rem_ff;
            assign den_src = g_stage[k-1].den_ff;
            assign pay_src = g_stage[k-1].pay_ff;
         end

         // Shift in the next dividend bit and try one subtract
         assign trial = {rem_src, nq_src[NUM_W-1]};
         assign qbit  = (trial >= {1'b0, den_src});
         assign diff  = trial - {1'b0, den_src};

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff <= 1'b0;
            end else if (en) begin
               v_ff <= v_src;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               nq_ff  <= {nq_src[NUM_W-2:0], qbit};
               rem_ff <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               den_ff <= den_src;
               pay_ff <= pay_src;
            end
         end
      end
   endgenerate

   assign out_valid = g_stage[NUM_W-1].v_ff;
   assign out_quo   = g_stage[NUM_W-1].nq_ff;
   assign out_pay   = g_stage[NUM_W-1].pay_ff;

endmodule

// File: design/ray_plane_intersection_top.sv
// Top level of the ray/plane intersection pipeline.
// Takes one ray per clock while the response is not stalled and returns one result per
// ray, in order. An accepted request beat passes four stages of dot products and
// magnitudes, a 53-stage divider that produces gamma one quotient bit per stage, two
// stages of point arithmetic and the output register. The whole pipeline advances
// whenever the output register is empty or being taken, so a stalled response holds
// every item in place. The user must write plane registers through the csr port only
// while no ray is in flight; the block does not enforce it. The csr port is always ready.
module ray_plane_intersection_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero fill
   input  logic [151:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // distance, point_x, point_y, point_z
   output logic [127:0] rsp_tdata,
   // hit
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   localparam int CW = rpi_pkg::COORD_W;
   localparam int VW = rpi_pkg::VEC_W;
   localparam int WB = rpi_pkg::WORD_BITS;
   localparam int FB = rpi_pkg::FRAC_BITS;

   // Plane registers
   logic signed [CW-1:0] cen_ff [0:2];
   logic signed [VW-1:0] nrm_ff [0:2];
   logic [rpi_pkg::THR_W-1:0] eps_ff;
   logic [rpi_pkg::THR_W-1:0] mg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cen_ff[0] <= '0;
         cen_ff[1] <= '0;
         cen_ff[2] <= '0;
         nrm_ff[0] <= '0;
         nrm_ff[1] <= '0;
         nrm_ff[2] <= rpi_pkg::NORMAL_Z_RESET;
         eps_ff    <= rpi_pkg::TAN_EPS_RESET;
         mg_ff     <= rpi_pkg::MIN_GAM_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            rpi_pkg::REG_CENTER_X: cen_ff[0] <= csr_data;
            rpi_pkg::REG_CENTER_Y: cen_ff[1] <= csr_data;
            rpi_pkg::REG_CENTER_Z: cen_ff[2] <= csr_data;
            rpi_pkg::REG_NORMAL_X: nrm_ff[0] <= csr_data[VW-1:0];
            rpi_pkg::REG_NORMAL_Y: nrm_ff[1] <= csr_data[VW-1:0];
            rpi_pkg::REG_NORMAL_Z: nrm_ff[2] <= csr_data[VW-1:0];
            rpi_pkg::REG_TAN_EPS:  eps_ff    <= csr_data[rpi_pkg::THR_W-1:0];
            rpi_pkg::REG_MIN_GAM:  mg_ff     <= csr_data[rpi_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   // Global advance: output empty or being taken
   logic en;
   logic rsp_tvalid_ff;
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   // Unpack the request beat
   logic signed [CW-1:0] in_org [0:2];
   logic signed [VW-1:0] in_dir [0:2];
   assign in_org[0] = req_tdata[31:0];
   assign in_org[1] = req_tdata[63:32];
   assign in_org[2] = req_tdata[95:64];
   assign in_dir[0] = req_tdata[113:96];
   assign in_dir[1] = req_tdata[131:114];
   assign in_dir[2] = req_tdata[149:132];

   // Stage 1: dir*normal and origin-center
   logic v1_ff;
   logic signed [rpi_pkg::DN_W-1:0]   dn1_ff   [0:2];
   logic signed [rpi_pkg::DIFF_W-1:0] diff1_ff [0:2];
   logic signed [CW-1:0] org1_ff [0:2];
   logic signed [VW-1:0] dir1_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            dn1_ff[i]   <= in_dir[i] * nrm_ff[i];
            diff1_ff[i] <= rpi_pkg::DIFF_W'(in_org[i]) - rpi_pkg::DIFF_W'(cen_ff[i]);
            org1_ff[i]  <= in_org[i];
            dir1_ff[i]  <= in_dir[i];
         end
      end
   end

   // Stage 2: cos sum and normal*diff
   logic v2_ff;
   logic signed [rpi_pkg::COS_W-1:0] cos2_ff;
   logic signed [rpi_pkg::ND_W-1:0]  nd2_ff  [0:2];
   logic signed [CW-1:0] org2_ff [0:2];
   logic signed [VW-1:0] dir2_ff [0:2];
   logic signed [rpi_pkg::COSF_W-1:0] cosf;

   assign cosf = rpi_pkg::COSF_W'(dn1_ff[0]) + rpi_pkg::COSF_W'(dn1_ff[1])
               + rpi_pkg::COSF_W'(dn1_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos2_ff <= cosf[rpi_pkg::COSF_W-1:FB];
         for (int i = 0; i < 3; i++) begin
            nd2_ff[i]  <= nrm_ff[i] * diff1_ff[i];
            org2_ff[i] <= org1_ff[i];
            dir2_ff[i] <= dir1_ff[i];
         end
      end
   end

   // Stage 3: dist sum
   logic v3_ff;
   logic signed [rpi_pkg::COS_W-1:0]  cos3_ff;
   logic signed [rpi_pkg::DIST_W-1:0] dist3_ff;
   logic signed [CW-1:0] org3_ff [0:2];
   logic signed [VW-1:0] dir3_ff [0:2];
   logic signed [rpi_pkg::DISTF_W-1:0] distf;

   assign distf = rpi_pkg::DISTF_W'(nd2_ff[0]) + rpi_pkg::DISTF_W'(nd2_ff[1])
                + rpi_pkg::DISTF_W'(nd2_ff[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos3_ff  <= cos2_ff;
         dist3_ff <= distf[rpi_pkg::DISTF_W-1:FB];
         for (int i = 0; i < 3; i++) begin
            org3_ff[i] <= org2_ff[i];
            dir3_ff[i] <= dir2_ff[i];
         end
      end
   end

   // Stage 4: magnitudes, parallel test, miss/hit distances
   logic v4_ff;
   logic [rpi_pkg::NUM_W-1:0] num4_ff;
   logic [rpi_pkg::DEN_W-1:0] den4_ff;
   rpi_pkg::pay_type pay4_ff;
   logic [rpi_pkg::DEN_W-1:0]  cabs;
   logic [rpi_pkg::DIST_W-1:0] dabs;
   rpi_pkg::pay_type pay4_in;

   assign cabs = cos3_ff[rpi_pkg::COS_W-1] ? rpi_pkg::DEN_W'(-cos3_ff)
                                           : rpi_pkg::DEN_W'(cos3_ff);
   assign dabs = dist3_ff[rpi_pkg::DIST_W-1] ? rpi_pkg::DIST_W'(-dist3_ff)
                                             : rpi_pkg::DIST_W'(dist3_ff);

   always_comb begin
      pay4_in.org_x    = org3_ff[0];
      pay4_in.org_y    = org3_ff[1];
      pay4_in.org_z    = org3_ff[2];
      pay4_in.dir_x    = dir3_ff[0];
      pay4_in.dir_y    = dir3_ff[1];
      pay4_in.dir_z    = dir3_ff[2];
      pay4_in.parallel = (cabs == '0) || (cabs < rpi_pkg::DEN_W'(eps_ff));
      // gamma = -dist/cos is negative when dist and cos share a sign
      pay4_in.neg      = !(dist3_ff[rpi_pkg::DIST_W-1] ^ cos3_ff[rpi_pkg::COS_W-1]);
      pay4_in.dist_miss = (dabs > rpi_pkg::DIST_W'({1'b0, {(WB-1){1'b1}}}))
                        ? {1'b0, {(WB-1){1'b1}}} : dabs[WB-1:0];
      pay4_in.dist_hit  = WB'(-$signed({1'b0, cabs}));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num4_ff <= {dabs, {FB{1'b0}}};
         den4_ff <= cabs;
         pay4_ff <= pay4_in;
      end
   end

   // Divider: |gamma| one bit per stage
   logic dv;
   logic [rpi_pkg::NUM_W-1:0] quo;
   rpi_pkg::pay_type dpay;

   rpi_div #(
      .NUM_W (rpi_pkg::NUM_W),
      .DEN_W (rpi_pkg::DEN_W),
      .PAY_W ($bits(rpi_pkg::pay_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_num    (num4_ff),
      .in_den    (den4_ff),
      .in_pay    (pay4_ff),
      .out_valid (dv),
      .out_quo   (quo),
      .out_pay   (dpay)
   );

   // Stage A: hit decision and partial products of gamma*dir
   logic va_ff;
   logic hita_ff;
   logic signed [rpi_pkg::PL_W-1:0] pla_ff [0:2];
   logic signed [rpi_pkg::PH_W-1:0] pha_ff [0:2];
   logic signed [CW-1:0] orga_ff [0:2];
   logic [WB-1:0] dmissa_ff;
   logic [WB-1:0] dhita_ff;
   logic signed [VW-1:0] ddir [0:2];
   logic signed [CW-1:0] dorg [0:2];
   logic signed [rpi_pkg::GL_W:0] gl;
   logic signed [rpi_pkg::GH_W:0] gh;
   logic hit_in;

   assign ddir[0] = dpay.dir_x;
   assign ddir[1] = dpay.dir_y;
   assign ddir[2] = dpay.dir_z;
   assign dorg[0] = dpay.org_x;
   assign dorg[1] = dpay.org_y;
   assign dorg[2] = dpay.org_z;
   assign gl = {1'b0, quo[rpi_pkg::GL_W-1:0]};
   assign gh = {1'b0, quo[rpi_pkg::NUM_W-1:rpi_pkg::GL_W]};
   assign hit_in = !dpay.parallel && (!dpay.neg || (quo == '0))
                && (quo >= rpi_pkg::NUM_W'(mg_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (en) begin
         va_ff <= dv;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hita_ff   <= hit_in;
         dmissa_ff <= dpay.dist_miss;
         dhita_ff  <= dpay.dist_hit;
         for (int i = 0; i < 3; i++) begin
            pla_ff[i]  <= gl * ddir[i];
            pha_ff[i]  <= gh * ddir[i];
            orga_ff[i] <= dorg[i];
         end
      end
   end

   // Stage B: combine partials, floor shift
   logic vb_ff;
   logic hitb_ff;
   logic signed [rpi_pkg::TS_W-1:0] tb_ff [0:2];
   logic signed [CW-1:0] orgb_ff [0:2];
   logic [WB-1:0] dmissb_ff;
   logic [WB-1:0] dhitb_ff;
   logic signed [rpi_pkg::T_W-1:0] tfull [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         tfull[i] = (rpi_pkg::T_W'(pha_ff[i]) <<< rpi_pkg::GL_W)
                  + rpi_pkg::T_W'(pla_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (en) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hitb_ff   <= hita_ff;
         dmissb_ff <= dmissa_ff;
         dhitb_ff  <= dhita_ff;
         for (int i = 0; i < 3; i++) begin
            tb_ff[i]   <= tfull[i][rpi_pkg::T_W-1:FB];
            orgb_ff[i] <= orga_ff[i];
         end
      end
   end

   // Stage C: add origin, saturate, select into the output register
   logic hit_ff;
   logic [WB-1:0] dist_ff;
   logic [WB-1:0] pt_ff [0:2];
   logic signed [rpi_pkg::SUM_W-1:0] psum [0:2];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         psum[i] = rpi_pkg::SUM_W'(orgb_ff[i]) + rpi_pkg::SUM_W'(tb_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         rsp_tvalid_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hitb_ff;
         dist_ff <= hitb_ff ? dhitb_ff : dmissb_ff;
         for (int i = 0; i < 3; i++) begin
            pt_ff[i] <= hitb_ff ? rpi_pkg::sat_word(psum[i]) : orgb_ff[i];
         end
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = hit_ff;
   assign rsp_tdata  = {pt_ff[2], pt_ff[1], pt_ff[0], dist_ff};

endmodule
